>>> rtl/core/bpa_pkg.sv
// shared types, widths and codes for the bitmap page allocator
package bpa_pkg;

  localparam int OP_W            = 2;
  localparam int PID_W           = 16;
  localparam int ST_W            = 3;
  localparam int GP_W            = 12;
  localparam int HWO_W           = 13;
  localparam int WORD_W          = 32;
  localparam int BIT_W           = 5;
  localparam int CMP_W           = PID_W + 1;
  localparam int IN_TDATA_W      = 24;
  localparam int OUT_TDATA_W     = 32;
  localparam int DEF_TOTAL_PAGES = 4096;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC_ANY = 2'd0,
    OP_ALLOC_AT  = 2'd1,
    OP_DISPOSE   = 2'd2,
    OP_CHECK     = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_RANGE     = 3'd2,
    ST_ALREADY   = 3'd3,
    ST_NOT_ALLOC = 3'd4
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic k_zero;
    logic k_inc;
    logic load_req;
    logic rd_req;
    logic rd_scan;
    logic exec;
    logic scan_take;
    logic scan_fail;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic k_last;
    logic slow;
    logic hit;
    logic out_free;
  } stat_t;

endpackage

>>> rtl/core/bitmap_page_allocator_unit.sv
// a request beat taken in idle passes the read and exec states; the result beat is registered
// as exec ends, and exec waits while an earlier result beat is not yet taken; in_tready is
// high only in idle, so requests are handled one at a time. allocate-any past capacity walks
// the bitmap memory one 32-page word at a time (scan read, then scan check); the bitmap read
// sets the pace. reset: synchronous, active low; afterwards a clearing pass zeroes the bitmap
// with in_tready low. high-water mark and result valid flag cleared at reset, result fields not
module bitmap_page_allocator_unit
  import bpa_pkg::*;
#(
  parameter int TOTAL_PAGES = DEF_TOTAL_PAGES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // opcode[1:0], page_id[17:2]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // status[2:0], granted_page[14:3], high_water[27:15]
);

  cmd_t  cmd;
  stat_t stat;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bpa_datapath #(
    .TOTAL_PAGES (TOTAL_PAGES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> rtl/core/bpa_ctrl.sv
// sequencing state machine for the bitmap page allocator
module bpa_ctrl
  import bpa_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EXEC,
    S_SCAN_RD,
    S_SCAN_CHK
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        cmd.k_inc  = 1'b1;
        if (stat.k_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          cmd.k_zero   = 1'b1;
          state_nxt    = S_RD;
        end
      end
      S_RD: begin
        if (stat.slow) begin
          state_nxt = S_SCAN_RD;
        end else begin
          cmd.rd_req = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        cmd.rd_req  = 1'b1;
        cmd.rd_scan = 1'b1;
        state_nxt   = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (stat.hit) begin
          if (stat.out_free) begin
            cmd.scan_take = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (stat.k_last) begin
          if (stat.out_free) begin
            cmd.scan_fail = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

>>> rtl/core/bpa_datapath.sv
// bitmap memory, high-water mark, request decode and result register
module bpa_datapath
  import bpa_pkg::*;
#(
  parameter int TOTAL_PAGES = DEF_TOTAL_PAGES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int WORDS = (TOTAL_PAGES + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int HW    = $clog2(TOTAL_PAGES + 1);

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rd_data_r;

  op_t             op_r;
  logic [PID_W-1:0] pid_r;
  logic [HW-1:0]    hwm_r;
  logic [AW-1:0]    k_r;

  logic             out_valid_r;
  status_t          out_st_r;
  logic [GP_W-1:0]  out_gp_r;
  logic [HWO_W-1:0] out_hw_r;

  logic [CMP_W-1:0] hwm_c, pid_c, tp_c;
  logic [AW-1:0]    req_addr, rd_addr, wr_addr;
  logic [BIT_W-1:0] req_bit, scan_bit;
  logic [WORD_W-1:0] req_mask, inv_word, low_zero, ex_word, wr_data;
  logic             bit_set, wr_en;
  status_t          ex_st;
  logic [GP_W-1:0]  ex_gp;
  logic [HW-1:0]    ex_hwm;
  logic [CMP_W-1:0] cand_c, ex_hwm_c;

  assign hwm_c = CMP_W'(hwm_r);
  assign pid_c = CMP_W'(pid_r);
  assign tp_c  = CMP_W'(TOTAL_PAGES);

  assign req_addr = (op_r == OP_ALLOC_ANY) ? hwm_c[BIT_W +: AW] : pid_r[BIT_W +: AW];
  assign req_bit  = (op_r == OP_ALLOC_ANY) ? hwm_c[BIT_W-1:0] : pid_r[BIT_W-1:0];
  assign req_mask = WORD_W'(1) << req_bit;
  assign bit_set  = |(rd_data_r & req_mask);

  // request decision on the word just read
  always_comb begin
    ex_st   = ST_OK;
    ex_gp   = '0;
    ex_hwm  = hwm_r;
    ex_word = rd_data_r;
    case (op_r)
      OP_ALLOC_ANY: begin
        ex_gp   = hwm_c[GP_W-1:0];
        ex_hwm  = hwm_r + HW'(1);
        ex_word = rd_data_r | req_mask;
      end
      OP_ALLOC_AT: begin
        if (pid_c >= tp_c) begin
          ex_st = ST_RANGE;
        end else if (pid_c < hwm_c) begin
          if (bit_set) begin
            ex_st = ST_ALREADY;
          end else begin
            ex_word = rd_data_r | req_mask;
          end
        end else begin
          ex_hwm  = HW'(pid_c + CMP_W'(1));
          ex_word = rd_data_r | req_mask;
        end
      end
      default: begin
        if (pid_c >= hwm_c) begin
          ex_st = ST_RANGE;
        end else if (!bit_set) begin
          ex_st = ST_NOT_ALLOC;
        end else if (op_r == OP_DISPOSE) begin
          ex_word = rd_data_r & ~req_mask;
        end
      end
    endcase
  end

  assign ex_hwm_c = CMP_W'(ex_hwm);

  // lowest clear bit of the scanned word
  assign inv_word = ~rd_data_r;
  assign low_zero = inv_word & (~inv_word + WORD_W'(1));

  always_comb begin
    scan_bit = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (low_zero[i]) begin
        scan_bit = scan_bit | BIT_W'(i);
      end
    end
  end

  assign cand_c = CMP_W'({k_r, scan_bit});

  assign stat.hit      = (rd_data_r != '1) && (cand_c < tp_c);
  assign stat.k_last   = (k_r == AW'(WORDS - 1));
  assign stat.slow     = (op_r == OP_ALLOC_ANY) && (hwm_c >= tp_c);
  assign stat.out_free = !out_valid_r || out_tready;

  assign rd_addr = cmd.rd_scan ? k_r : req_addr;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = req_addr;
    wr_data = ex_word;
    if (cmd.clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = k_r;
      wr_data = '0;
    end else if (cmd.scan_take) begin
      wr_en   = 1'b1;
      wr_addr = k_r;
      wr_data = rd_data_r | low_zero;
    end else if (cmd.exec) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_req) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hwm_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.k_zero) begin
        k_r <= '0;
      end else if (cmd.k_inc) begin
        k_r <= k_r + AW'(1);
      end
      if (cmd.exec) begin
        hwm_r <= ex_hwm;
      end
      if (cmd.exec || cmd.scan_take || cmd.scan_fail) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r  <= op_t'(in_tdata[OP_W-1:0]);
      pid_r <= in_tdata[OP_W +: PID_W];
    end
    if (cmd.exec) begin
      out_st_r <= ex_st;
      out_gp_r <= ex_gp;
      out_hw_r <= ex_hwm_c[HWO_W-1:0];
    end else if (cmd.scan_take) begin
      out_st_r <= ST_OK;
      out_gp_r <= cand_c[GP_W-1:0];
      out_hw_r <= hwm_c[HWO_W-1:0];
    end else if (cmd.scan_fail) begin
      out_st_r <= ST_NO_SPACE;
      out_gp_r <= '0;
      out_hw_r <= hwm_c[HWO_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - HWO_W - GP_W - ST_W)'(0), out_hw_r, out_gp_r, out_st_r};

endmodule
